/* rtl/lph_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared widths, reset values and result codes of the hash table block.
// ----------------------------------------------------------------------------
package lph_pkg;

    // Default sizing of the slot store.
    localparam int MAX_SLOTS_DEFAULT = 1024;
    localparam int KEY_BITS_DEFAULT  = 32;

    // Fixed field widths of the streaming and configuration ports.
    localparam int SIZE_W   = 11;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 10;
    localparam int COLL_W   = 11;
    localparam int ECHO_W   = 32;

    // Table size after reset.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // Result codes carried on the master tuser.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_FOUND     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

endpackage

/* rtl/lph_mod_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division that produces dividend modulo divisor, one quotient
// bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module lph_mod_unit #(
    parameter int DIVIDEND_W = lph_pkg::KEY_BITS_DEFAULT,
    parameter int DIVISOR_W  = $clog2(lph_pkg::MAX_SLOTS_DEFAULT + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVISOR_W-1:0]  rem_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic [DIVISOR_W-1:0]  rem_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg}) begin
            rem_next = DIVISOR_W'(diff);
        end else begin
            rem_next = DIVISOR_W'(trial);
        end
    end

    // Step control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/lph_slot_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot store
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lph_slot_ram #(
    parameter int DEPTH  = lph_pkg::MAX_SLOTS_DEFAULT,
    parameter int DATA_W = lph_pkg::KEY_BITS_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing hash table that inserts or searches keys, starting at the
// key modulo the table size and probing one slot at a time with wrap-around.
//
//   Channel  Direction  tdata (low bit up)                 tuser
//   s_       in         key                                command
//   m_       out        slot, collisions, key_echo, pad    status
//   cfg_     in         table_size on cfg_wdata            -
//
// An item passes through the remainder unit (its done flag is registered),
// ST_START to start the first read, ST_PROBE with one probed slot per step
// (collisions + 1 slots, or the table size on a sweep with no outcome),
// ST_RESP to load the output register and ST_IDLE with s_tready high before
// the next request transfer. The single read port of the slot store sets the
// probe rate of one slot a cycle. After reset the store is cleared one slot a
// cycle while s_tready stays low. A result held by m_tready stalls the next
// finished item in ST_RESP, and s_tready stays low until it is loaded.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int MAX_SLOTS = lph_pkg::MAX_SLOTS_DEFAULT,
    parameter int KEY_BITS  = lph_pkg::KEY_BITS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration write.
    input  logic                       cfg_we,
    input  logic [lph_pkg::SIZE_W-1:0] cfg_wdata,    // table_size
    // Request stream.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,      // key
    input  logic                       s_tuser,      // command
    // Result stream.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [55:0]                m_tdata,      // slot, collisions, key_echo, zero pad
    output logic [1:0]                 m_tuser       // status
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int NW = $clog2(MAX_SLOTS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_SLOTS - 1);
    localparam logic [NW-1:0] MAX_N     = NW'(MAX_SLOTS);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_START = 6'b001000,
        ST_PROBE = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [lph_pkg::SIZE_W-1:0]      size_reg;
    logic [AW-1:0]                   clr_addr_reg;
    logic                            search_reg;
    logic [KEY_BITS-1:0]             key_reg;
    logic [lph_pkg::ECHO_W-1:0]      echo_reg;
    logic [NW-1:0]                   n_reg;
    logic [AW-1:0]                   pos_reg;
    logic [NW-1:0]                   passed_reg;
    lph_pkg::status_t                res_status_reg;
    logic [lph_pkg::SLOT_W-1:0]      res_slot_reg;
    logic [lph_pkg::COLL_W-1:0]      res_coll_reg;
    logic                            m_tvalid_reg;
    logic [55:0]                     m_tdata_reg;
    logic [1:0]                      m_tuser_reg;

    logic                            in_xfer;
    logic                            out_load;
    logic [KEY_BITS-1:0]             key_in;
    logic [lph_pkg::ECHO_W-1:0]      echo_in;
    logic [NW-1:0]                   n_in;
    logic                            div_done;
    logic [NW-1:0]                   div_rem;
    logic [NW-1:0]                   pos_p1;
    logic [AW-1:0]                   pos_step;
    logic [NW-1:0]                   passed_p1;
    logic [KEY_BITS-1:0]             held;
    logic                            held_empty;
    logic                            held_match;
    logic                            probe_end;
    lph_pkg::status_t                probe_status;
    logic [lph_pkg::SLOT_W-1:0]      probe_slot;
    logic [lph_pkg::COLL_W-1:0]      probe_coll;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [KEY_BITS-1:0]             mem_wdata;
    logic [AW-1:0]                   mem_raddr;
    logic [KEY_BITS-1:0]             mem_rdata_w;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_RESP) && (!m_tvalid_reg || m_tready);

    // Key limited to the stored key width, and its echo at the port width.
    always_comb begin
        for (int i = 0; i < KEY_BITS; i++) begin
            key_in[i] = (i < lph_pkg::KEY_W) ? s_tdata[i % lph_pkg::KEY_W] : 1'b0;
        end
        for (int i = 0; i < lph_pkg::ECHO_W; i++) begin
            echo_in[i] = (i < KEY_BITS) ? s_tdata[i] : 1'b0;
        end
    end

    // Slots in use: a zero size counts as one, and sizes above the store saturate.
    always_comb begin
        if (size_reg == '0) begin
            n_in = NW'(1);
        end else if (32'(size_reg) > 32'(MAX_SLOTS)) begin
            n_in = MAX_N;
        end else begin
            n_in = NW'(size_reg);
        end
    end

    lph_mod_unit #(
        .DIVIDEND_W (KEY_BITS),
        .DIVISOR_W  (NW)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (in_xfer),
        .dividend  (key_in),
        .divisor   (n_in),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Next probe position with wrap-around at the table size.
    always_comb begin
        pos_p1    = NW'(pos_reg) + 1'b1;
        pos_step  = (pos_p1 >= n_reg) ? '0 : AW'(pos_p1);
        passed_p1 = passed_reg + 1'b1;
    end

    // Probe evaluation on the slot that the memory returns this cycle.
    always_comb begin
        held         = mem_rdata_w;
        held_empty   = (held == '0);
        held_match   = search_reg && (held == key_reg);
        probe_end    = 1'b0;
        probe_status = search_reg ? lph_pkg::STATUS_NOT_FOUND : lph_pkg::STATUS_FULL;
        probe_slot   = '0;
        probe_coll   = lph_pkg::COLL_W'(passed_reg);
        if (held_empty) begin
            probe_end = 1'b1;
            if (!search_reg) begin
                probe_status = lph_pkg::STATUS_INSERTED;
                probe_slot   = lph_pkg::SLOT_W'(pos_reg);
            end
        end else if (held_match) begin
            probe_end    = 1'b1;
            probe_status = lph_pkg::STATUS_FOUND;
            probe_slot   = lph_pkg::SLOT_W'(pos_reg);
        end else if (passed_p1 == n_reg) begin
            probe_end  = 1'b1;
            probe_coll = lph_pkg::COLL_W'(passed_p1);
        end
    end

    // Memory port selection: the clearing sweep or the insert write, and the read address.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = key_reg;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else if ((state_reg == ST_PROBE) && held_empty && !search_reg) begin
            mem_we = 1'b1;
        end
        mem_raddr = (state_reg == ST_PROBE) ? pos_step : pos_reg;
    end

    lph_slot_ram #(
        .DEPTH  (MAX_SLOTS),
        .DATA_W (KEY_BITS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata_w)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_PROBE;
            end
            ST_PROBE: begin
                if (probe_end) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            size_reg     <= lph_pkg::SIZE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request and probe payload.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            search_reg <= s_tuser;
            key_reg    <= key_in;
            echo_reg   <= echo_in;
            n_reg      <= n_in;
        end
        if ((state_reg == ST_DIV) && div_done) begin
            pos_reg    <= AW'(div_rem);
            passed_reg <= '0;
        end else if ((state_reg == ST_PROBE) && !probe_end) begin
            pos_reg    <= pos_step;
            passed_reg <= passed_p1;
        end
        if ((state_reg == ST_PROBE) && probe_end) begin
            res_status_reg <= probe_status;
            res_slot_reg   <= probe_slot;
            res_coll_reg   <= probe_coll;
        end
    end

    // Output register; a waiting transfer holds until m_tready.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {3'b000, echo_reg, res_coll_reg, res_slot_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
